### hw/rtl/bmp_pkg.sv
// ----------------------------------------------------------------------------
// bmp_pkg
// Shared types and constants for the BMP stream decoder.
// ----------------------------------------------------------------------------
`default_nettype none
package bmp_pkg;

  localparam int MaxDimDefault = 4096;
  localparam int HdrBytes      = 54;
  localparam int PalMax        = 4 * 256;
  localparam logic [15:0] BmpSig = 16'h4D42;

  localparam logic [1:0] KIND_RGB    = 2'd0;
  localparam logic [1:0] KIND_RAW    = 2'd1;
  localparam logic [1:0] KIND_HDR_OK = 2'd2;
  localparam logic [1:0] KIND_REJECT = 2'd3;

  localparam logic [3:0] ST_OK       = 4'd0;
  localparam logic [3:0] ST_SIG      = 4'd1;
  localparam logic [3:0] ST_COMP     = 4'd2;
  localparam logic [3:0] ST_WIDTH    = 4'd3;
  localparam logic [3:0] ST_HEIGHT   = 4'd4;
  localparam logic [3:0] ST_DEPTH    = 4'd5;
  localparam logic [3:0] ST_SIZE     = 4'd6;
  localparam logic [3:0] ST_OFS_LOW  = 4'd7;
  localparam logic [3:0] ST_OFS_HIGH = 4'd8;
  localparam logic [3:0] ST_TRUNC    = 4'd9;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_data;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  raw_byte;
    logic [11:0] row;
    logic [13:0] column;
    logic [12:0] image_width;
    logic [12:0] image_height;
    logic [5:0]  bit_depth;
    logic [3:0]  status;
    logic        last;
  } out_word_t;

  // controller -> datapath
  typedef struct packed {
    logic take;      // process the held byte
    logic calc;      // one step of header size calculation
    logic calc_init;
    logic finish;    // apply header verdict
  } bmp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic need_calc; // byte 53 captured, checks pending
    logic calc_done;
  } bmp_sts_t;

endpackage
`default_nettype wire

### hw/rtl/bmp_datapath.sv
// ----------------------------------------------------------------------------
// bmp_datapath
// Header field capture, header checks, pixel unpacking and result register.
// ----------------------------------------------------------------------------
`default_nettype none
module bmp_datapath #(
  parameter int MAX_DIM = bmp_pkg::MaxDimDefault
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire bmp_pkg::in_word_t  in_word,
  input  wire bmp_pkg::bmp_cmd_t  cmd,
  output bmp_pkg::bmp_sts_t       sts,
  output bmp_pkg::out_word_t      res,
  output logic                    res_vld
);

  localparam logic [1:0] PH_HEADER  = 2'd0;
  localparam logic [1:0] PH_PALETTE = 2'd1;
  localparam logic [1:0] PH_PIXELS  = 2'd2;
  localparam logic [1:0] PH_SKIP    = 2'd3;

  logic [1:0]  phase_r, phase_nxt;
  logic [5:0]  pos_r, pos_nxt;
  logic [10:0] pal_pos_r, pal_pos_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic [31:0] wid_r, wid_nxt, hgt_r, hgt_nxt, comp_r, comp_nxt, decl_r, decl_nxt;
  logic [15:0] dep_r, dep_nxt, ofs_r, ofs_nxt;
  logic        pend_r, pend_nxt;
  logic        eod_r, eod_nxt;
  logic [31:0] rowb_r, rowb_nxt;
  logic [47:0] tot_r, tot_nxt;
  logic [1:0]  cstep_r, cstep_nxt;
  logic [14:0] rbc_r, rbc_nxt, col_r, col_nxt;
  logic [12:0] crow_r, crow_nxt;
  logic [15:0] pix_r, pix_nxt;
  logic [1:0]  bip_r, bip_nxt;
  bmp_pkg::out_word_t res_nxt;
  logic        vld_nxt;

  logic [31:0] hdr_acc;
  logic [3:0]  verdict;
  logic [12:0] toprow;
  logic        lastrow, fin;
  logic [15:0] row_limit;
  logic [37:0] wd_prod;
  logic [16:0] rowb_next;
  logic [14:0] rbc_inc;

  assign hdr_acc   = {in_word.data_byte, acc_r[31:8]};
  assign wd_prod   = {6'd0, wid_r} * {22'd0, dep_r} + 38'd31;
  assign toprow    = hgt_r[12:0] - 13'd1 - crow_r;
  assign lastrow   = (crow_r == hgt_r[12:0] - 13'd1);
  assign row_limit = 16'(3 * {1'b0, wid_r[14:0]});
  assign rbc_inc   = rbc_r + 15'd1;
  assign rowb_next = {2'b00, rbc_r} + 17'd1;

  assign sts.need_calc = pend_r;
  assign sts.calc_done = (cstep_r == 2'd2);

  always_comb begin
    verdict = bmp_pkg::ST_OK;
    if (comp_r != 32'd0) verdict = bmp_pkg::ST_COMP;
    else if (wid_r[31] || wid_r == 32'd0 || wid_r > 32'(MAX_DIM)) verdict = bmp_pkg::ST_WIDTH;
    else if (hgt_r[31] || hgt_r == 32'd0 || hgt_r > 32'(MAX_DIM)) verdict = bmp_pkg::ST_HEIGHT;
    else if (dep_r[15] || dep_r == 16'd0 || dep_r > 16'd32) verdict = bmp_pkg::ST_DEPTH;
    else if (decl_r != 32'd0 && {16'd0, decl_r} != tot_r) verdict = bmp_pkg::ST_SIZE;
    else if (ofs_r[15] || ofs_r < 16'(bmp_pkg::HdrBytes)) verdict = bmp_pkg::ST_OFS_LOW;
    else if (ofs_r > 16'(bmp_pkg::HdrBytes + bmp_pkg::PalMax)) verdict = bmp_pkg::ST_OFS_HIGH;
  end

  always_comb begin
    phase_nxt = phase_r; pos_nxt = pos_r; pal_pos_nxt = pal_pos_r; acc_nxt = acc_r;
    wid_nxt = wid_r; hgt_nxt = hgt_r; comp_nxt = comp_r; decl_nxt = decl_r;
    dep_nxt = dep_r; ofs_nxt = ofs_r; pend_nxt = pend_r; rowb_nxt = rowb_r;
    tot_nxt = tot_r; cstep_nxt = cstep_r; rbc_nxt = rbc_r; col_nxt = col_r;
    crow_nxt = crow_r; pix_nxt = pix_r; bip_nxt = bip_r; fin = 1'b0;
    eod_nxt = eod_r;
    res_nxt = '0; vld_nxt = 1'b0;

    if (cmd.calc_init) cstep_nxt = 2'd0;
    if (cmd.calc) begin
      if (cstep_r == 2'd0) begin
        rowb_nxt = {wd_prod[34:5], 2'b00};
        cstep_nxt = 2'd1;
      end else if (cstep_r == 2'd1) begin
        tot_nxt = {16'd0, rowb_r * {16'd0, hgt_r[15:0]}};
        cstep_nxt = 2'd2;
      end
    end

    if (cmd.finish) begin
      pend_nxt = 1'b0;
      res_nxt.last = 1'b1; vld_nxt = 1'b1;
      if (verdict != bmp_pkg::ST_OK) begin
        res_nxt.kind = bmp_pkg::KIND_REJECT; res_nxt.status = verdict;
        phase_nxt = PH_SKIP;
      end else begin
        res_nxt.kind = bmp_pkg::KIND_HDR_OK; res_nxt.last = 1'b0;
        res_nxt.image_width = wid_r[12:0]; res_nxt.image_height = hgt_r[12:0];
        res_nxt.bit_depth = dep_r[5:0];
        phase_nxt = (ofs_r == 16'(bmp_pkg::HdrBytes)) ? PH_PIXELS : PH_PALETTE;
      end
      if (eod_r && phase_nxt != PH_SKIP) begin
        res_nxt = '0; res_nxt.kind = bmp_pkg::KIND_REJECT;
        res_nxt.status = bmp_pkg::ST_TRUNC; res_nxt.last = 1'b1;
      end
      if (eod_r) begin
        phase_nxt = PH_HEADER; pos_nxt = '0; pal_pos_nxt = '0; acc_nxt = '0;
        wid_nxt = '0; hgt_nxt = '0; comp_nxt = '0; decl_nxt = '0; dep_nxt = '0;
        ofs_nxt = '0; rbc_nxt = '0; col_nxt = '0; crow_nxt = '0; pix_nxt = '0;
        bip_nxt = '0; rowb_nxt = '0;
      end
      eod_nxt = 1'b0;
    end else if (cmd.take) begin
      unique case (phase_r)
        PH_HEADER: begin
          acc_nxt = hdr_acc;
          pos_nxt = pos_r + 6'd1;
          pal_pos_nxt = 11'(pos_r) + 11'd1;
          case (pos_r)
            6'd1: if (hdr_acc[31:16] != bmp_pkg::BmpSig) begin
              res_nxt.kind = bmp_pkg::KIND_REJECT; res_nxt.status = bmp_pkg::ST_SIG;
              res_nxt.last = 1'b1; vld_nxt = 1'b1; phase_nxt = PH_SKIP;
            end
            6'd11: ofs_nxt  = hdr_acc[31:16];
            6'd21: wid_nxt  = hdr_acc;
            6'd25: hgt_nxt  = hdr_acc;
            6'd29: dep_nxt  = hdr_acc[31:16];
            6'd33: comp_nxt = hdr_acc;
            6'd37: decl_nxt = hdr_acc;
            6'd53: begin
              pend_nxt = 1'b1; eod_nxt = in_word.end_of_data;
            end
            default: ;
          endcase
        end
        PH_PALETTE: begin
          pal_pos_nxt = pal_pos_r + 11'd1;
          if ({5'd0, pal_pos_nxt} >= ofs_r) phase_nxt = PH_PIXELS;
        end
        PH_PIXELS: begin
          if (dep_r[5:0] == 6'd24) begin
            if ({1'b0, rbc_r} < row_limit) begin
              if (bip_r == 2'd0) begin
                pix_nxt = {8'd0, in_word.data_byte}; bip_nxt = 2'd1;
              end else if (bip_r == 2'd1) begin
                pix_nxt = {in_word.data_byte, pix_r[7:0]}; bip_nxt = 2'd2;
              end else begin
                fin = lastrow && (col_r == wid_r[14:0] - 15'd1);
                res_nxt.kind = bmp_pkg::KIND_RGB; res_nxt.red = in_word.data_byte;
                res_nxt.green = pix_r[15:8]; res_nxt.blue = pix_r[7:0];
                res_nxt.row = toprow[11:0]; res_nxt.column = col_r[13:0];
                res_nxt.last = fin; vld_nxt = 1'b1;
                col_nxt = col_r + 15'd1; bip_nxt = 2'd0;
              end
            end
          end else begin
            fin = lastrow && ({17'd0, rbc_r} == rowb_r - 32'd1);
            res_nxt.kind = bmp_pkg::KIND_RAW; res_nxt.raw_byte = in_word.data_byte;
            res_nxt.row = toprow[11:0]; res_nxt.column = rbc_r[13:0];
            res_nxt.last = fin; vld_nxt = 1'b1;
          end
          if (fin) phase_nxt = PH_SKIP;
          rbc_nxt = rbc_inc;
          if ({15'd0, rowb_next} >= rowb_r) begin
            rbc_nxt = '0; col_nxt = '0; bip_nxt = 2'd0;
            crow_nxt = crow_r + 13'd1;
            if (lastrow) phase_nxt = PH_SKIP;
          end
        end
        default: ;
      endcase
      if (in_word.end_of_data && !pend_nxt) begin
        if (phase_nxt != PH_SKIP) begin
          res_nxt = '0; res_nxt.kind = bmp_pkg::KIND_REJECT;
          res_nxt.status = bmp_pkg::ST_TRUNC; res_nxt.last = 1'b1; vld_nxt = 1'b1;
        end
        phase_nxt = PH_HEADER; pos_nxt = '0; pal_pos_nxt = '0; acc_nxt = '0;
        wid_nxt = '0; hgt_nxt = '0; comp_nxt = '0; decl_nxt = '0; dep_nxt = '0;
        ofs_nxt = '0; rbc_nxt = '0; col_nxt = '0; crow_nxt = '0; pix_nxt = '0;
        bip_nxt = '0; rowb_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEADER; pos_r <= '0; pal_pos_r <= '0; acc_r <= '0;
      wid_r <= '0; hgt_r <= '0; comp_r <= '0; decl_r <= '0; dep_r <= '0;
      ofs_r <= '0; pend_r <= 1'b0; rowb_r <= '0; tot_r <= '0; cstep_r <= '0;
      rbc_r <= '0; col_r <= '0; crow_r <= '0; pix_r <= '0; bip_r <= '0;
      eod_r <= 1'b0;
      res_vld <= 1'b0;
    end else begin
      phase_r <= phase_nxt; pos_r <= pos_nxt; pal_pos_r <= pal_pos_nxt; acc_r <= acc_nxt;
      wid_r <= wid_nxt; hgt_r <= hgt_nxt; comp_r <= comp_nxt; decl_r <= decl_nxt;
      dep_r <= dep_nxt; ofs_r <= ofs_nxt; pend_r <= pend_nxt; rowb_r <= rowb_nxt;
      tot_r <= tot_nxt; cstep_r <= cstep_nxt; rbc_r <= rbc_nxt; col_r <= col_nxt;
      crow_r <= crow_nxt; pix_r <= pix_nxt; bip_r <= bip_nxt;
      eod_r <= eod_nxt;
      res_vld <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res <= res_nxt;
  end

endmodule
`default_nettype wire

### hw/rtl/bmp_ctrl.sv
// ----------------------------------------------------------------------------
// bmp_ctrl
// Handshake control: byte holding register, header check sequencing and
// output register.
// ----------------------------------------------------------------------------
`default_nettype none
module bmp_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire bmp_pkg::in_word_t  in_data,
  output bmp_pkg::in_word_t       word_q,
  output bmp_pkg::bmp_cmd_t       cmd,
  input  wire bmp_pkg::bmp_sts_t  sts,
  input  wire bmp_pkg::out_word_t res,
  input  wire logic               res_vld,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output bmp_pkg::out_word_t      out_data
);

  localparam logic [1:0] S_RUN   = 2'd0;
  localparam logic [1:0] S_CALC  = 2'd1;
  localparam logic [1:0] S_FIN   = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       full_r, full_nxt;
  bmp_pkg::in_word_t word_r;
  logic       ov_r, ov_nxt;
  logic       slot_free, go;

  // a byte is processed only if the output slot can take a result
  assign slot_free = !res_vld && (!ov_r || !out_stall);
  assign go        = full_r && slot_free && (state_r == S_RUN) && !sts.need_calc;
  assign in_stall  = full_r && !go;
  assign word_q    = word_r;
  assign out_valid = ov_r;

  always_comb begin
    cmd = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_RUN: begin
        cmd.take = go;
        if (sts.need_calc) begin
          cmd.calc_init = 1'b1; state_nxt = S_CALC;
        end
      end
      S_CALC: begin
        cmd.calc = 1'b1;
        if (sts.calc_done) state_nxt = S_FIN;
      end
      S_FIN: if (slot_free) begin
        cmd.finish = 1'b1; state_nxt = S_RUN;
      end
      default: state_nxt = S_RUN;
    endcase
  end

  always_comb begin
    full_nxt = full_r;
    if (go && !(sts.need_calc)) full_nxt = 1'b0;
    if (in_valid && !in_stall) full_nxt = 1'b1;
    ov_nxt = ov_r;
    if (ov_r && !out_stall) ov_nxt = 1'b0;
    if (res_vld) ov_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_RUN; full_r <= 1'b0; ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt; full_r <= full_nxt; ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) word_r <= in_data;
    if (res_vld) out_data <= res;
  end

endmodule
`default_nettype wire

### hw/rtl/bmp_stream_decoder_top.sv
// An accepted byte passes the datapath result register and the output
// register; byte 53 adds the header size checks (start, two multiplier steps,
// hand-over, verdict). Bytes without a result go one per cycle while the output
// slot is free; a result or the checks of byte 53 hold the next byte back.
// Reset: synchronous active-low rst_n clears all control and header state.
// ----------------------------------------------------------------------------
// bmp_stream_decoder_top
// Uncompressed BMP byte stream decoder.
// ----------------------------------------------------------------------------
`default_nettype none
module bmp_stream_decoder_top #(
  parameter int MAX_DIM = bmp_pkg::MaxDimDefault
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire bmp_pkg::in_word_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output bmp_pkg::out_word_t      out_data
);

  bmp_pkg::in_word_t  word_q;
  bmp_pkg::bmp_cmd_t  cmd;
  bmp_pkg::bmp_sts_t  sts;
  bmp_pkg::out_word_t res;
  logic               res_vld;

  bmp_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .in_data, .word_q, .cmd, .sts,
    .res, .res_vld, .out_valid, .out_stall, .out_data
  );

  bmp_datapath #(.MAX_DIM(MAX_DIM)) u_dp (
    .clk, .rst_n, .in_word(word_q), .cmd, .sts, .res, .res_vld
  );

endmodule
`default_nettype wire
